/* hdl/tbts_pkg.sv */
// shared types, constants and the microprogram of the tone shaper
`default_nettype none
package tbts_pkg;

  localparam int SampleW = 24;
  localparam int IntW    = 32;
  localparam int Frac    = 24;
  localparam int KnobW   = 16;
  localparam int IdxW    = 8;
  localparam int StepW   = 7;

  localparam logic signed [IntW-1:0] QOne   = 32'sd16777216;
  localparam logic signed [IntW-1:0] QNeg1  = -32'sd16777216;
  localparam logic signed [IntW-1:0] QHalf  = 32'sd8388608;
  localparam logic signed [IntW-1:0] Q044   = 32'sd7381975;
  localparam logic signed [IntW-1:0] Q03    = 32'sd5033165;
  localparam logic signed [IntW-1:0] Q0777  = 32'sd13035897;
  localparam logic signed [IntW-1:0] Q068   = 32'sd11408507;
  localparam logic signed [IntW-1:0] Q0157  = 32'sd2634023;
  localparam logic signed [IntW-1:0] Q8     = 32'sd134217728;

  localparam logic [IdxW-1:0] RegTreble = 8'd0;
  localparam logic [IdxW-1:0] RegMid    = 8'd1;
  localparam logic [IdxW-1:0] RegBass   = 8'd2;
  localparam logic [IdxW-1:0] RegCross  = 8'd3;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_ABS, OP_MIN, OP_MAX, OP_CSEL, OP_OUT
  } op_e;

  typedef enum logic [5:0] {
    R_ZERO, R_ONE, R_NEG1, R_CH, R_C044, R_C03, R_C0777, R_C068, R_C0157, R_C8,
    R_X, R_AH0, R_AH1, R_AH2, R_AH3, R_AG, R_GA,
    R_SA0, R_SA1, R_SA2, R_SD0, R_SD1, R_SD2, R_PR, R_PG, R_PS0, R_PS1, R_PS2,
    R_T0, R_T1, R_T2, R_T3, R_T4, R_T5, R_T6, R_T7, R_T8, R_T9,
    R_GT, R_GM, R_GB, R_KC
  } src_e;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_MULW} state_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e d;
  } uop_t;

  typedef struct packed {
    logic load_x;
    logic en_alu;
    logic en_mprod;
    logic en_mwb;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic uop_t ucode(input logic [StepW-1:0] step);
    uop_t u;
    case (step)
      // predictive high split
      7'd0:   u = '{OP_SUB, R_AH3, R_AH2, R_T0};
      7'd1:   u = '{OP_SUB, R_AH2, R_AH1, R_T1};
      7'd2:   u = '{OP_SUB, R_AH1, R_AH0, R_T2};
      7'd3:   u = '{OP_SUB, R_AH0, R_X, R_T3};
      7'd4:   u = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd5:   u = '{OP_SUB, R_T1, R_T2, R_T4};
      7'd6:   u = '{OP_SUB, R_T2, R_T3, R_T2};
      7'd7:   u = '{OP_SUB, R_T0, R_T4, R_T0};
      7'd8:   u = '{OP_SUB, R_T4, R_T2, R_T4};
      7'd9:   u = '{OP_ADD, R_AH0, R_T1, R_T1};
      7'd10:  u = '{OP_ADD, R_T1, R_T0, R_T1};
      7'd11:  u = '{OP_ADD, R_T0, R_T4, R_T0};
      7'd12:  u = '{OP_MUL, R_T0, R_CH, R_T0};
      7'd13:  u = '{OP_SUB, R_T1, R_T0, R_T1};
      7'd14:  u = '{OP_SUB, R_ZERO, R_T1, R_T1};
      7'd15:  u = '{OP_SUB, R_X, R_T1, R_T0};
      7'd16:  u = '{OP_ABS, R_T0, R_ZERO, R_T0};
      7'd17:  u = '{OP_MUL, R_T0, R_CH, R_T0};
      7'd18:  u = '{OP_MUL, R_AG, R_CH, R_T2};
      7'd19:  u = '{OP_ADD, R_T2, R_T0, R_T2};
      7'd20:  u = '{OP_MIN, R_T2, R_C03, R_AG};
      7'd21:  u = '{OP_ADD, R_AH2, R_ZERO, R_AH3};
      7'd22:  u = '{OP_ADD, R_AH1, R_ZERO, R_AH2};
      7'd23:  u = '{OP_ADD, R_AH0, R_ZERO, R_AH1};
      7'd24:  u = '{OP_MUL, R_AG, R_T1, R_T0};
      7'd25:  u = '{OP_ADD, R_T0, R_X, R_AH0};
      7'd26:  u = '{OP_MUL, R_T1, R_CH, R_T0};
      7'd27:  u = '{OP_MUL, R_X, R_C044, R_T2};
      7'd28:  u = '{OP_ADD, R_T0, R_T2, R_T0};
      7'd29:  u = '{OP_SUB, R_X, R_T0, R_T0};
      7'd30:  u = '{OP_ADD, R_T0, R_GA, R_T2};
      7'd31:  u = '{OP_ADD, R_T0, R_ZERO, R_GA};
      7'd32:  u = '{OP_MUL, R_T2, R_CH, R_T5};
      7'd33:  u = '{OP_SUB, R_X, R_T5, R_T6};
      // slew filter
      7'd34:  u = '{OP_MUL, R_KC, R_KC, R_T7};
      7'd35:  u = '{OP_SUB, R_ONE, R_T7, R_T8};
      7'd36:  u = '{OP_MUL, R_T5, R_T7, R_T0};
      7'd37:  u = '{OP_MUL, R_T0, R_C0777, R_T9};
      7'd38:  u = '{OP_MUL, R_T9, R_T7, R_T0};
      7'd39:  u = '{OP_SUB, R_PS2, R_PS1, R_T1};
      7'd40:  u = '{OP_ADD, R_SA2, R_T1, R_T1};
      7'd41:  u = '{OP_MUL, R_T1, R_CH, R_SA2};
      7'd42:  u = '{OP_SUB, R_PS1, R_PS0, R_T1};
      7'd43:  u = '{OP_ADD, R_SA1, R_T1, R_T1};
      7'd44:  u = '{OP_MUL, R_T1, R_CH, R_SA1};
      7'd45:  u = '{OP_SUB, R_PS0, R_T0, R_T1};
      7'd46:  u = '{OP_ADD, R_SA0, R_T1, R_T1};
      7'd47:  u = '{OP_MUL, R_T1, R_CH, R_SA0};
      7'd48:  u = '{OP_SUB, R_SA2, R_SA1, R_T1};
      7'd49:  u = '{OP_ADD, R_SD1, R_T1, R_T1};
      7'd50:  u = '{OP_MUL, R_T1, R_CH, R_SD1};
      7'd51:  u = '{OP_SUB, R_SA1, R_SA0, R_T1};
      7'd52:  u = '{OP_ADD, R_SD0, R_T1, R_T1};
      7'd53:  u = '{OP_MUL, R_T1, R_CH, R_SD0};
      7'd54:  u = '{OP_SUB, R_SD1, R_SD0, R_T1};
      7'd55:  u = '{OP_ADD, R_SD2, R_T1, R_T1};
      7'd56:  u = '{OP_MUL, R_T1, R_CH, R_SD2};
      7'd57:  u = '{OP_ADD, R_PS0, R_SA1, R_T1};
      7'd58:  u = '{OP_ADD, R_T1, R_SD2, R_T1};
      7'd59:  u = '{OP_ADD, R_PR, R_T1, R_T1};
      7'd60:  u = '{OP_MUL, R_T1, R_CH, R_PR};
      7'd61:  u = '{OP_SUB, R_T9, R_PR, R_T1};
      7'd62:  u = '{OP_ABS, R_T1, R_ZERO, R_T1};
      7'd63:  u = '{OP_MUL, R_T1, R_T8, R_T1};
      7'd64:  u = '{OP_MUL, R_T1, R_C8, R_T1};
      7'd65:  u = '{OP_ADD, R_PG, R_T1, R_T1};
      7'd66:  u = '{OP_MUL, R_T1, R_CH, R_T1};
      7'd67:  u = '{OP_MUL, R_T8, R_CH, R_T2};
      7'd68:  u = '{OP_MIN, R_T1, R_T2, R_PG};
      7'd69:  u = '{OP_MUL, R_T8, R_C0157, R_T1};
      7'd70:  u = '{OP_ADD, R_C068, R_T1, R_T1};
      7'd71:  u = '{OP_SUB, R_ONE, R_T1, R_T1};
      7'd72:  u = '{OP_MUL, R_T9, R_T1, R_T1};
      7'd73:  u = '{OP_ADD, R_PR, R_T1, R_PR};
      7'd74:  u = '{OP_ADD, R_PS1, R_ZERO, R_PS2};
      7'd75:  u = '{OP_ADD, R_PS0, R_ZERO, R_PS1};
      7'd76:  u = '{OP_MUL, R_PG, R_PR, R_T1};
      7'd77:  u = '{OP_SUB, R_ONE, R_PG, R_T2};
      7'd78:  u = '{OP_MUL, R_T2, R_T9, R_T2};
      7'd79:  u = '{OP_ADD, R_T1, R_T2, R_T1};
      7'd80:  u = '{OP_MIN, R_T1, R_ONE, R_T1};
      7'd81:  u = '{OP_MAX, R_T1, R_NEG1, R_PS0};
      7'd82:  u = '{OP_MUL, R_PR, R_C0777, R_T0};
      7'd83:  u = '{OP_SUB, R_T5, R_T0, R_T5};
      // band gains and sum
      7'd84:  u = '{OP_MUL, R_GB, R_GB, R_T1};
      7'd85:  u = '{OP_SUB, R_ONE, R_GB, R_T2};
      7'd86:  u = '{OP_MUL, R_T2, R_T2, R_T2};
      7'd87:  u = '{OP_SUB, R_ONE, R_T2, R_T3};
      7'd88:  u = '{OP_CSEL, R_GB, R_T1, R_T3};
      7'd89:  u = '{OP_MUL, R_T0, R_T3, R_T4};
      7'd90:  u = '{OP_MUL, R_GM, R_GM, R_T1};
      7'd91:  u = '{OP_SUB, R_ONE, R_GM, R_T2};
      7'd92:  u = '{OP_MUL, R_T2, R_T2, R_T2};
      7'd93:  u = '{OP_SUB, R_ONE, R_T2, R_T3};
      7'd94:  u = '{OP_CSEL, R_GM, R_T1, R_T3};
      7'd95:  u = '{OP_MUL, R_T5, R_T3, R_T3};
      7'd96:  u = '{OP_ADD, R_T4, R_T3, R_T4};
      7'd97:  u = '{OP_MUL, R_GT, R_GT, R_T1};
      7'd98:  u = '{OP_MUL, R_T1, R_T1, R_T1};
      7'd99:  u = '{OP_SUB, R_ONE, R_GT, R_T2};
      7'd100: u = '{OP_MUL, R_T2, R_T2, R_T2};
      7'd101: u = '{OP_SUB, R_ONE, R_T2, R_T3};
      7'd102: u = '{OP_CSEL, R_GT, R_T1, R_T3};
      7'd103: u = '{OP_MUL, R_T6, R_T3, R_T3};
      7'd104: u = '{OP_ADD, R_T4, R_T3, R_T4};
      default: u = '{OP_OUT, R_T4, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* hdl/tbts_ctrl.sv */
// sequencer that steps the datapath through the per-sample microprogram
`default_nettype none
module tbts_ctrl import tbts_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  uop_t             uop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    uop        = ucode(step_q);
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.uop  = uop;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          step_d       = '0;
          state_d      = S_RUN;
        end
      end
      S_RUN: begin
        if (uop.op == OP_MUL) begin
          cmd_o.en_mprod = 1'b1;
          state_d        = S_MULW;
        end else if (uop.op == OP_OUT) begin
          // hold until the previous result has been taken
          if (!stat_i.out_busy) begin
            cmd_o.en_alu = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          cmd_o.en_alu = 1'b1;
          step_d       = step_q + 1'b1;
        end
      end
      S_MULW: begin
        cmd_o.en_mwb = 1'b1;
        step_d       = step_q + 1'b1;
        state_d      = S_RUN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_mwb_after_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.en_mwb |-> $past(cmd_o.en_mprod))
    else $error("multiply writeback without product capture");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a sample is in flight");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.en_alu && cmd_o.uop.op == OP_OUT) |-> !stat_i.out_busy)
    else $error("result written over an untaken result");

endmodule
`default_nettype wire

/* hdl/tbts_datapath.sv */
// register set, shared multiplier, saturating alu, knob and output registers
`default_nettype none
module tbts_datapath import tbts_pkg::*; (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  cmd_t                      cmd_i,
  output stat_t                     stat_o,
  input  wire  signed [SampleW-1:0] sample_in_i,
  input  wire                       cfg_valid_i,
  input  wire         [IdxW-1:0]    cfg_index_i,
  input  wire         [KnobW-1:0]   cfg_data_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic signed [SampleW-1:0] sample_out_o
);

  logic signed [IntW-1:0] x_q, ah0_q, ah1_q, ah2_q, ah3_q, ag_q, ga_q;
  logic signed [IntW-1:0] sa0_q, sa1_q, sa2_q, sd0_q, sd1_q, sd2_q, pr_q, pg_q;
  logic signed [IntW-1:0] ps0_q, ps1_q, ps2_q;
  logic signed [IntW-1:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q, t8_q, t9_q;
  logic [KnobW-1:0]       kt_q, km_q, kb_q, kx_q;
  logic [2*IntW-1:0]      prod_q;
  logic                   neg_q;
  logic                   out_valid_q;
  logic signed [SampleW-1:0] out_q;

  logic signed [IntW-1:0] va, vb, vd, wdata;
  logic                   wen;
  logic [IntW-1:0]        ma, mb;
  logic [2*IntW:0]        rnd;
  logic [IntW:0]          rmag;
  logic signed [IntW+1:0] mres;
  logic signed [IntW:0]   sum33, dif33;
  logic [IntW:0]          omag, ohalf;
  logic signed [IntW+1:0] oval;
  logic signed [SampleW-1:0] osat;

  function automatic logic signed [IntW-1:0] sat_w(input logic signed [IntW+1:0] v);
    logic signed [IntW+1:0] hi, lo;
    hi = 34'sd2147483647;
    lo = -34'sd2147483648;
    if (v > hi) return hi[IntW-1:0];
    if (v < lo) return lo[IntW-1:0];
    return v[IntW-1:0];
  endfunction

  function automatic logic signed [IntW-1:0] rd(input src_e s);
    logic signed [IntW-1:0] r;
    case (s)
      R_ZERO:  r = '0;
      R_ONE:   r = QOne;
      R_NEG1:  r = QNeg1;
      R_CH:    r = QHalf;
      R_C044:  r = Q044;
      R_C03:   r = Q03;
      R_C0777: r = Q0777;
      R_C068:  r = Q068;
      R_C0157: r = Q0157;
      R_C8:    r = Q8;
      R_X:     r = x_q;
      R_AH0:   r = ah0_q;
      R_AH1:   r = ah1_q;
      R_AH2:   r = ah2_q;
      R_AH3:   r = ah3_q;
      R_AG:    r = ag_q;
      R_GA:    r = ga_q;
      R_SA0:   r = sa0_q;
      R_SA1:   r = sa1_q;
      R_SA2:   r = sa2_q;
      R_SD0:   r = sd0_q;
      R_SD1:   r = sd1_q;
      R_SD2:   r = sd2_q;
      R_PR:    r = pr_q;
      R_PG:    r = pg_q;
      R_PS0:   r = ps0_q;
      R_PS1:   r = ps1_q;
      R_PS2:   r = ps2_q;
      R_T0:    r = t0_q;
      R_T1:    r = t1_q;
      R_T2:    r = t2_q;
      R_T3:    r = t3_q;
      R_T4:    r = t4_q;
      R_T5:    r = t5_q;
      R_T6:    r = t6_q;
      R_T7:    r = t7_q;
      R_T8:    r = t8_q;
      R_T9:    r = t9_q;
      // band gain is twice the knob, crossover is the knob itself
      R_GT:    r = {7'b0, kt_q, 9'b0};
      R_GM:    r = {7'b0, km_q, 9'b0};
      R_GB:    r = {7'b0, kb_q, 9'b0};
      R_KC:    r = {8'b0, kx_q, 8'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    va    = rd(cmd_i.uop.a);
    vb    = rd(cmd_i.uop.b);
    vd    = rd(cmd_i.uop.d);
    ma    = va[IntW-1] ? IntW'(-va) : IntW'(va);
    mb    = vb[IntW-1] ? IntW'(-vb) : IntW'(vb);
    sum33 = {va[IntW-1], va} + {vb[IntW-1], vb};
    dif33 = {va[IntW-1], va} - {vb[IntW-1], vb};
    // rounded product, magnitude capped at 2^31 before the sign goes back on
    rnd   = {1'b0, prod_q} + (65'd1 << (Frac-1));
    rmag  = (rnd[2*IntW:Frac] > 41'h0080000000) ? 33'h080000000 : rnd[Frac+IntW:Frac];
    mres  = neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    // output conversion: halve with rounding, then clip to the sample range
    omag  = va[IntW-1] ? (IntW+1)'(-{va[IntW-1], va}) : {1'b0, va};
    ohalf = (omag + 33'd1) >> 1;
    oval  = va[IntW-1] ? -$signed({1'b0, ohalf}) : $signed({1'b0, ohalf});
    if (oval > 34'sd8388607)       osat = 24'sh7fffff;
    else if (oval < -34'sd8388608) osat = 24'sh800000;
    else                           osat = oval[SampleW-1:0];

    wen   = 1'b0;
    wdata = '0;
    if (cmd_i.en_mwb) begin
      wen   = 1'b1;
      wdata = sat_w(mres);
    end else if (cmd_i.en_alu) begin
      wen = 1'b1;
      case (cmd_i.uop.op)
        OP_ADD:  wdata = sat_w({sum33[IntW], sum33});
        OP_SUB:  wdata = sat_w({dif33[IntW], dif33});
        OP_ABS:  wdata = sat_w(va[IntW-1] ? -{{2{va[IntW-1]}}, va} : {2'b0, va});
        OP_MIN:  wdata = (va > vb) ? vb : va;
        OP_MAX:  wdata = (va < vb) ? vb : va;
        OP_CSEL: wdata = (va > QOne) ? vb : vd;
        default: wen   = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en_mprod) begin
      prod_q <= ma * mb;
      neg_q  <= va[IntW-1] ^ vb[IntW-1];
    end
    if (cmd_i.en_alu && cmd_i.uop.op == OP_OUT) out_q <= osat;
    if (wen) begin
      case (cmd_i.uop.d)
        R_T0: t0_q <= wdata;
        R_T1: t1_q <= wdata;
        R_T2: t2_q <= wdata;
        R_T3: t3_q <= wdata;
        R_T4: t4_q <= wdata;
        R_T5: t5_q <= wdata;
        R_T6: t6_q <= wdata;
        R_T7: t7_q <= wdata;
        R_T8: t8_q <= wdata;
        R_T9: t9_q <= wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0; ah0_q <= '0; ah1_q <= '0; ah2_q <= '0; ah3_q <= '0;
      ag_q <= '0; ga_q <= '0; sa0_q <= '0; sa1_q <= '0; sa2_q <= '0;
      sd0_q <= '0; sd1_q <= '0; sd2_q <= '0; pr_q <= '0; pg_q <= '0;
      ps0_q <= '0; ps1_q <= '0; ps2_q <= '0;
      kt_q <= 16'h8000; km_q <= 16'h8000; kb_q <= 16'h8000; kx_q <= 16'h8000;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_x) x_q <= {{(IntW-SampleW-1){sample_in_i[SampleW-1]}}, sample_in_i, 1'b0};
      if (wen) begin
        case (cmd_i.uop.d)
          R_AH0: ah0_q <= wdata;
          R_AH1: ah1_q <= wdata;
          R_AH2: ah2_q <= wdata;
          R_AH3: ah3_q <= wdata;
          R_AG:  ag_q  <= wdata;
          R_GA:  ga_q  <= wdata;
          R_SA0: sa0_q <= wdata;
          R_SA1: sa1_q <= wdata;
          R_SA2: sa2_q <= wdata;
          R_SD0: sd0_q <= wdata;
          R_SD1: sd1_q <= wdata;
          R_SD2: sd2_q <= wdata;
          R_PR:  pr_q  <= wdata;
          R_PG:  pg_q  <= wdata;
          R_PS0: ps0_q <= wdata;
          R_PS1: ps1_q <= wdata;
          R_PS2: ps2_q <= wdata;
          default: ;
        endcase
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegTreble: kt_q <= cfg_data_i;
          RegMid:    km_q <= cfg_data_i;
          RegBass:   kb_q <= cfg_data_i;
          RegCross:  kx_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.en_alu && cmd_i.uop.op == OP_OUT) out_valid_q <= 1'b1;
      else if (out_ready_i)                        out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_q;

endmodule
`default_nettype wire

/* hdl/three_band_tone_shaper_core.sv */
// three-band tone shaper: top level joining sequencer and datapath
// operation: each input transaction runs 105 microprogram steps, 37 of them
// multiplies on the shared 32x32 multiplier that capture the product and then write
// it back, then the output step; no sample is taken while these run, the next is
// taken while the previous result waits, the output step holds until it is taken
// reset: asynchronous active low, clears filter state, knobs go to 0x8000
`default_nettype none
module three_band_tone_shaper_core import tbts_pkg::*; (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  signed [SampleW-1:0] sample_in_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic signed [SampleW-1:0] sample_out_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire         [IdxW-1:0]    cfg_index_i,
  input  wire         [KnobW-1:0]   cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tbts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbts_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .sample_in_i  (sample_in_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule
`default_nettype wire
